// File: rtl/jed_pkg.sv
`timescale 1ns / 1ps

package jed_pkg;

  // Most result words one input word can cause.
  localparam int GRP_MAX = 5;
  localparam int GRP_CNT_W = 3;

  typedef logic [1:0] kind_t;

  localparam kind_t K_PLAIN = 2'd0;
  localparam kind_t K_ESC   = 2'd1;
  localparam kind_t K_REPL  = 2'd2;
  localparam kind_t K_UNK   = 2'd3;

  // All result words caused by one input word.
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [GRP_MAX-1:0][1:0] kinds;
    logic [GRP_CNT_W-1:0]    cnt;
  } grp_t;

endpackage

// File: rtl/jed_in_if.sv
`timescale 1ns / 1ps

interface jed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: rtl/jed_out_if.sv
`timescale 1ns / 1ps

interface jed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output out_kind, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input last_of_run,
                output ready);
endinterface

// File: rtl/jed_front.sv
`timescale 1ns / 1ps

module jed_front (
  input  logic          clk,
  input  logic          rst,
  jed_in_if.sink        in_ch,
  input  logic          full,
  output logic          push,
  output jed_pkg::grp_t push_grp
);
  import jed_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_HEX1    = 3'd2;
  localparam logic [2:0] PH_WANT_BS = 3'd3;
  localparam logic [2:0] PH_WANT_U  = 3'd4;
  localparam logic [2:0] PH_HEX2    = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    grp_t g;
    logic to_want;
  } fin_t;

  function automatic grp_t grp_put(grp_t g, logic [7:0] b, kind_t k);
    grp_t r;
    r = g;
    if (g.cnt < GRP_CNT_W'(GRP_MAX)) begin
      r.bytes[g.cnt] = b;
      r.kinds[g.cnt] = k;
      r.cnt          = g.cnt + GRP_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic grp_t grp_fffd(grp_t g);
    grp_t r;
    r = grp_put(g, 8'hEF, K_REPL);
    r = grp_put(r, 8'hBF, K_REPL);
    r = grp_put(r, 8'hBD, K_REPL);
    return r;
  endfunction

  function automatic grp_t grp_utf8(grp_t g, logic [20:0] cp);
    grp_t r;
    r = g;
    if (cp < 21'h80) begin
      r = grp_put(r, cp[7:0], K_ESC);
    end else if (cp < 21'h800) begin
      r = grp_put(r, {3'b110, cp[10:6]}, K_ESC);
      r = grp_put(r, {2'b10, cp[5:0]}, K_ESC);
    end else if (cp < 21'h10000) begin
      r = grp_put(r, {4'b1110, cp[15:12]}, K_ESC);
      r = grp_put(r, {2'b10, cp[11:6]}, K_ESC);
      r = grp_put(r, {2'b10, cp[5:0]}, K_ESC);
    end else begin
      r = grp_put(r, {5'b11110, cp[20:18]}, K_ESC);
      r = grp_put(r, {2'b10, cp[17:12]}, K_ESC);
      r = grp_put(r, {2'b10, cp[11:6]}, K_ESC);
      r = grp_put(r, {2'b10, cp[5:0]}, K_ESC);
    end
    return r;
  endfunction

  // Close a \u run. First half: low surrogate is an error, high surrogate
  // waits for its partner. Second half must be a low surrogate.
  function automatic fin_t do_finish(grp_t g, logic second, logic [15:0] v,
                                     logic [9:0] hi);
    fin_t r;
    r.g       = g;
    r.to_want = 1'b0;
    if (second) begin
      if (v[15:10] == 6'b110111) begin
        r.g = grp_utf8(g, 21'h10000 + {1'b0, hi, v[9:0]});
      end else begin
        r.g = grp_fffd(g);
      end
    end else if (v[15:10] == 6'b110111) begin
      r.g = grp_fffd(g);
    end else if (v[15:10] == 6'b110110) begin
      r.to_want = 1'b1;
    end else begin
      r.g = grp_utf8(g, {5'd0, v});
    end
    return r;
  endfunction

  // {hit, byte} for the one-byte escapes
  function automatic logic [8:0] simple_esc(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  logic [2:0]  phase;
  logic [2:0]  digit_count;
  logic [15:0] hex_accum;
  logic [9:0]  high_half;

  logic [2:0]  phase_next;
  logic [2:0]  digit_count_next;
  logic [15:0] hex_accum_next;
  logic [9:0]  high_half_next;

  grp_t        g;
  fin_t        f;
  logic        redo;
  logic        fin;
  logic        dig_ok;
  logic [3:0]  dig;
  logic [8:0]  sesc;
  logic [7:0]  b;
  logic        take;

  assign b    = in_ch.in_byte;
  assign take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !full;
  assign push        = take && (g.cnt != '0);
  assign push_grp    = g;

  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dig_ok = 1'b1;
      dig    = b[3:0];
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dig_ok = 1'b1;
      dig    = b[3:0] + 4'd9;
    end
  end

  assign sesc = simple_esc(b);

  always_comb begin
    g                = '0;
    f                = '0;
    fin              = 1'b0;
    redo             = 1'b0;
    phase_next       = phase;
    digit_count_next = digit_count;
    hex_accum_next   = hex_accum;
    high_half_next   = high_half;
    if (in_ch.end_of_text) begin
      unique case (phase)
        PH_ESC: begin
          g = grp_put(g, CH_BSLASH, K_UNK);
        end
        PH_HEX1: begin
          f = do_finish(g, 1'b0, hex_accum, high_half);
          g = f.g;
          if (f.to_want) g = grp_fffd(g);
        end
        PH_WANT_BS: begin
          g = grp_fffd(g);
        end
        PH_WANT_U: begin
          g = grp_fffd(g);
          g = grp_put(g, CH_BSLASH, K_UNK);
        end
        PH_HEX2: begin
          f = do_finish(g, 1'b1, hex_accum, high_half);
          g = f.g;
        end
        default: ;
      endcase
      phase_next       = PH_IDLE;
      digit_count_next = '0;
      hex_accum_next   = '0;
      high_half_next   = '0;
    end else begin
      // at most three passes: hex end, then surrogate wait, then plain byte
      redo = 1'b1;
      for (int s = 0; s < 3; s++) begin
        if (redo) begin
          redo = 1'b0;
          unique case (phase_next)
            PH_ESC: begin
              if (b == CH_U) begin
                phase_next       = PH_HEX1;
                digit_count_next = '0;
                hex_accum_next   = '0;
              end else begin
                if (sesc[8]) begin
                  g = grp_put(g, sesc[7:0], K_ESC);
                end else begin
                  g = grp_put(g, CH_BSLASH, K_UNK);
                  g = grp_put(g, b, K_UNK);
                end
                phase_next = PH_IDLE;
              end
            end
            PH_HEX1, PH_HEX2: begin
              if (dig_ok) begin
                hex_accum_next   = {hex_accum_next[11:0], dig};
                digit_count_next = digit_count_next + 3'd1;
                fin              = (digit_count_next == 3'd4);
              end else begin
                fin  = 1'b1;
                redo = 1'b1;
              end
              if (fin) begin
                f = do_finish(g, phase_next == PH_HEX2, hex_accum_next, high_half_next);
                g = f.g;
                if (f.to_want) begin
                  high_half_next = hex_accum_next[9:0];
                  phase_next     = PH_WANT_BS;
                end else begin
                  phase_next = PH_IDLE;
                end
                hex_accum_next   = '0;
                digit_count_next = '0;
              end
            end
            PH_WANT_BS: begin
              if (b == CH_BSLASH) begin
                phase_next = PH_WANT_U;
              end else begin
                g          = grp_fffd(g);
                phase_next = PH_IDLE;
                redo       = 1'b1;
              end
            end
            PH_WANT_U: begin
              if (b == CH_U) begin
                phase_next       = PH_HEX2;
                digit_count_next = '0;
                hex_accum_next   = '0;
              end else begin
                g          = grp_fffd(g);
                phase_next = PH_ESC;
                redo       = 1'b1;
              end
            end
            default: begin
              if (b == CH_BSLASH) begin
                phase_next = PH_ESC;
              end else begin
                phase_next = PH_IDLE;
                g          = grp_put(g, b, K_PLAIN);
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digit_count <= '0;
      hex_accum   <= '0;
      high_half   <= '0;
    end else if (take) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      hex_accum   <= hex_accum_next;
      high_half   <= high_half_next;
    end
  end

endmodule

// File: rtl/jed_queue.sv
`timescale 1ns / 1ps

module jed_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jed_pkg::grp_t push_grp,
  output logic          full,
  input  logic          pop,
  output jed_pkg::grp_t head,
  output logic          empty
);
  import jed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

// File: rtl/jed_back.sv
`timescale 1ns / 1ps

module jed_back (
  input  logic          clk,
  input  logic          rst,
  input  jed_pkg::grp_t head,
  input  logic          empty,
  output logic          pop,
  jed_out_if.source     out_ch
);
  import jed_pkg::*;

  grp_t                 cur;
  logic [GRP_CNT_W-1:0] pos;
  logic                 busy;
  logic                 last;
  logic                 take;
  logic                 done;

  assign last = (pos == cur.cnt - GRP_CNT_W'(1));
  assign take = out_ch.valid && out_ch.ready;
  assign done = !busy || (take && last);
  assign pop  = done && !empty;

  assign out_ch.valid       = busy;
  assign out_ch.out_byte    = cur.bytes[pos];
  assign out_ch.out_kind    = cur.kinds[pos];
  assign out_ch.last_of_run = last;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (take) begin
      pos <= pos + GRP_CNT_W'(1);
    end
  end

endmodule

// File: rtl/json_escape_to_utf8_decoder.sv
`timescale 1ns / 1ps

// JSON string escape decoder. Text bytes come in on in_ch, one word per cycle
// while the queue has room, and decoded bytes leave on out_ch, one word per
// cycle while out_ch is ready. Plain bytes pass through; backslash escapes are
// decoded, \u runs (lowercase hex, up to four digits) become UTF-8, surrogate
// pairs become 4-byte UTF-8, and surrogate errors become U+FFFD. A word with
// end_of_text set flushes any open escape and returns the decoder to its idle
// state. The front end decodes a whole input word in the cycle it is accepted
// and files all of its result words (up to five) as one group into a queue of
// QUEUE_DEPTH groups; the back end drains the queue one byte per cycle while
// out_ch is ready and marks the last byte of each group with last_of_run. Input
// words are taken every cycle while the queue has room, so the input side
// sustains one word per cycle as long as each word causes at most one result
// on average and out_ch is ready; a word causing k results holds the output
// port until all k are taken, which bounds the sustained rate. A word's first
// result byte passes through the queue and the back end's cur register.
module json_escape_to_utf8_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  jed_in_if.sink    in_ch,
  jed_out_if.source out_ch
);
  import jed_pkg::*;

  // group handoff between the decode front end and the output back end
  logic push;
  logic pop;
  logic full;
  logic empty;
  grp_t push_grp;
  grp_t head;

  jed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .full     (full),
    .push     (push),
    .push_grp (push_grp)
  );

  jed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  jed_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // never file a group into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("group pushed into full queue");

  // back end only pops real groups
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("group popped from empty queue");

  // every filed group holds between one and the max result words
  a_grp_size: assert property (@(posedge clk) disable iff (rst)
      push |-> (push_grp.cnt != '0 && push_grp.cnt <= GRP_CNT_W'(GRP_MAX)))
    else $error("bad group size");

  // output only goes quiet right after the last word of a group was taken
  a_drop_on_last: assert property (@(posedge clk) disable iff (rst)
      $fell(out_ch.valid) |-> $past(out_ch.ready && out_ch.last_of_run))
    else $error("output dropped mid-group");
`endif

endmodule

// File: tb/tb_json_escape_to_utf8_decoder.sv
`timescale 1ns / 1ps

// Self-checking bench for the JSON escape decoder. Text words go in on in_ch;
// a scoreboard decodes each accepted word on its own and queues the result
// words it should cause. Every word taken from out_ch is compared against the
// oldest queued one.
module tb_json_escape_to_utf8_decoder;
  import jed_pkg::*;

  // Cycles with no handshake on either port before the run is called hung.
  localparam int IDLE_LIMIT   = 1000;
  // Extra cycles after the queue empties, to catch stray output words.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 64;
  localparam int NUM_PHASES   = 4;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U = 8'h75;

  // Decoder position, tracked by the scoreboard.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ESC,
    ST_HEX1,
    ST_WANT_BS,
    ST_WANT_U,
    ST_HEX2
  } dec_state_e;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } out_word_t;

  class utf8_scoreboard;
    dec_state_e  st;
    logic [2:0]  ndig;
    logic [15:0] acc;
    logic [9:0]  hi;
    out_word_t   step_q[$];
    out_word_t   expected_q[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      st   = ST_IDLE;
      ndig = '0;
      acc  = '0;
      hi   = '0;
    endfunction

    function void emit(logic [7:0] data, kind_t kind);
      out_word_t w;
      w.data = data;
      w.kind = kind;
      w.last = 1'b0;
      step_q.push_back(w);
    endfunction

    // U+FFFD
    function void emit_fffd();
      emit(8'hEF, K_REPL);
      emit(8'hBF, K_REPL);
      emit(8'hBD, K_REPL);
    endfunction

    function void emit_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        emit(cp[7:0], K_ESC);
      end else if (cp < 21'h800) begin
        emit({3'b110, cp[10:6]}, K_ESC);
        emit({2'b10, cp[5:0]}, K_ESC);
      end else if (cp < 21'h10000) begin
        emit({4'b1110, cp[15:12]}, K_ESC);
        emit({2'b10, cp[11:6]}, K_ESC);
        emit({2'b10, cp[5:0]}, K_ESC);
      end else begin
        emit({5'b11110, cp[20:18]}, K_ESC);
        emit({2'b10, cp[17:12]}, K_ESC);
        emit({2'b10, cp[11:6]}, K_ESC);
        emit({2'b10, cp[5:0]}, K_ESC);
      end
    endfunction

    function void close_first();
      logic [15:0] v;
      v    = acc;
      acc  = '0;
      ndig = '0;
      if (v >= 16'hDC00 && v <= 16'hDFFF) begin
        emit_fffd();
        st = ST_IDLE;
      end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
        hi = v[9:0];
        st = ST_WANT_BS;
      end else begin
        emit_utf8({5'd0, v});
        st = ST_IDLE;
      end
    endfunction

    function void close_second();
      logic [15:0] v;
      v    = acc;
      acc  = '0;
      ndig = '0;
      if (v < 16'hDC00 || v > 16'hDFFF) emit_fffd();
      else emit_utf8(21'h10000 + {1'b0, hi, v[9:0]});
      st = ST_IDLE;
    endfunction

    function void close_run();
      if (st == ST_HEX1) close_first();
      else close_second();
    endfunction

    function void flush();
      case (st)
        ST_ESC: emit(BSLASH, K_UNK);
        ST_HEX1: begin
          close_first();
          if (st == ST_WANT_BS) emit_fffd();
        end
        ST_WANT_BS: emit_fffd();
        ST_WANT_U: begin
          emit_fffd();
          emit(BSLASH, K_UNK);
        end
        ST_HEX2: close_second();
        default: ;
      endcase
      clear_state();
    endfunction

    // A byte that ends a run or breaks a pair is handled again in the new state.
    function void take(logic [7:0] b);
      bit again;
      int d;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (st)
          ST_ESC: begin
            if (b == CHAR_U) begin
              st   = ST_HEX1;
              ndig = '0;
              acc  = '0;
            end else begin
              case (b)
                8'h22, BSLASH, 8'h2F: emit(b, K_ESC);
                "b": emit(8'h08, K_ESC);
                "f": emit(8'h0C, K_ESC);
                "n": emit(8'h0A, K_ESC);
                "r": emit(8'h0D, K_ESC);
                "t": emit(8'h09, K_ESC);
                default: begin
                  emit(BSLASH, K_UNK);
                  emit(b, K_UNK);
                end
              endcase
              st = ST_IDLE;
            end
          end
          ST_HEX1, ST_HEX2: begin
            // lowercase only; 'A'-'F' end the run
            if (b >= "0" && b <= "9") d = b - 8'h30;
            else if (b >= "a" && b <= "f") d = b - 8'h57;
            else d = -1;
            if (d >= 0) begin
              acc = {acc[11:0], d[3:0]};
              ndig++;
              if (ndig >= 3'd4) close_run();
            end else begin
              close_run();
              again = 1'b1;
            end
          end
          ST_WANT_BS: begin
            if (b == BSLASH) begin
              st = ST_WANT_U;
            end else begin
              emit_fffd();
              st    = ST_IDLE;
              again = 1'b1;
            end
          end
          ST_WANT_U: begin
            if (b == CHAR_U) begin
              st   = ST_HEX2;
              ndig = '0;
              acc  = '0;
            end else begin
              // the taken backslash opens a fresh escape
              emit_fffd();
              st    = ST_ESC;
              again = 1'b1;
            end
          end
          default: begin
            st = ST_IDLE;
            if (b == BSLASH) st = ST_ESC;
            else emit(b, K_PLAIN);
          end
        endcase
      end
    endfunction

    function void note_input(logic [7:0] b, logic eot);
      out_word_t w;
      step_q.delete();
      if (eot) flush();
      else take(b);
      if (step_q.size() > 0) begin
        w = step_q.pop_back();
        w.last = 1'b1;
        step_q.push_back(w);
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_output(logic [7:0] data, kind_t kind, logic last);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %h kind %0d last %b",
                 $time, data, kind, last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (data !== want.data) begin
          $display("%0t: out_byte expected %h got %h", $time, want.data, data);
          errors++;
        end
        if (kind !== want.kind) begin
          $display("%0t: out_kind expected %0d got %0d", $time, want.kind, kind);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  jed_in_if  in_ch();
  jed_out_if out_ch();

  json_escape_to_utf8_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_scoreboard sb;

  // Idle/stall odds in percent, changed per phase.
  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int idle_tab [NUM_PHASES]  = '{0, 46, 0, 21};
  int stall_tab [NUM_PHASES] = '{0, 0, 46, 21};

  logic [7:0] simple_chars [8] = '{8'h22, BSLASH, 8'h2F, "b", "f", "n", "r", "t"};

  always #5 clk = ~clk;

  // Receiver: ready changes only at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output monitor: a word moves at a rising edge with valid and ready high.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_output(out_ch.out_byte, out_ch.out_kind, out_ch.last_of_run);
  end

  // Watchdog: too many cycles without any handshake ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_json_escape_to_utf8_decoder: errors");
    $finish;
  end

  // Present one word, with random idle cycles ahead of it, and hold it until
  // the block takes it. Valid is left high so back-to-back words need no gap.
  task automatic send_word(input logic [7:0] b, input logic eot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    sb.note_input(b, eot);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // First n lowercase hex digits of v, most significant first.
  task automatic send_hex(input logic [15:0] v, input int n);
    int i;
    logic [3:0] nib;
    for (i = 0; i < n; i++) begin
      nib = v[15 - 4*i -: 4];
      send_word((nib < 4'd10) ? 8'h30 + nib : 8'h57 + nib, 1'b0);
    end
  endtask

  // Code unit spread over every single-unit UTF-8 length and both surrogate halves.
  function automatic logic [15:0] random_cp();
    logic [15:0] v;
    case ($urandom_range(4))
      0: v = 16'($urandom_range(16'h007F, 16'h0000));
      1: v = 16'($urandom_range(16'h07FF, 16'h0080));
      2: v = 16'($urandom_range(16'hFFFF, 16'h0800));
      3: v = 16'($urandom_range(16'hDBFF, 16'hD800));
      default: v = 16'($urandom_range(16'hDFFF, 16'hDC00));
    endcase
    return v;
  endfunction

  // One random token: mostly well-formed escapes with random content, plus
  // raw bytes, broken pairs and end-of-text at arbitrary points.
  task automatic send_random_token();
    int pick;
    logic [15:0] hi_v;
    logic [15:0] lo_v;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_word(8'($urandom), 1'b0);
    end else if (pick < 45) begin
      send_word(BSLASH, 1'b0);
      send_word(simple_chars[$urandom_range(7)], 1'b0);
    end else if (pick < 53) begin
      send_word(BSLASH, 1'b0);
      send_word(8'($urandom), 1'b0);
    end else if (pick < 73) begin
      // single \u, one time in four cut short
      send_word(BSLASH, 1'b0);
      send_word(CHAR_U, 1'b0);
      send_hex(random_cp(), ($urandom_range(3) == 0) ? $urandom_range(3) : 4);
    end else if (pick < 94) begin
      hi_v = 16'($urandom_range(16'hDBFF, 16'hD800));
      lo_v = 16'($urandom_range(16'hDFFF, 16'hDC00));
      send_word(BSLASH, 1'b0);
      send_word(CHAR_U, 1'b0);
      send_hex(hi_v, 4);
      case ($urandom_range(11))
        0: send_word(8'($urandom), 1'b0);            // random byte after high half
        1: begin                                     // second escape with a random byte
          send_word(BSLASH, 1'b0);
          send_word(8'($urandom), 1'b0);
        end
        2: begin                                     // arbitrary second half
          send_word(BSLASH, 1'b0);
          send_word(CHAR_U, 1'b0);
          send_hex(16'($urandom), 4);
        end
        3: begin                                     // short second half
          send_word(BSLASH, 1'b0);
          send_word(CHAR_U, 1'b0);
          send_hex(lo_v, $urandom_range(3));
        end
        4: send_word(8'($urandom), 1'b1);            // end right after high half
        5: begin                                     // end after second backslash
          send_word(BSLASH, 1'b0);
          send_word(8'($urandom), 1'b1);
        end
        default: begin
          send_word(BSLASH, 1'b0);
          send_word(CHAR_U, 1'b0);
          send_hex(lo_v, 4);
        end
      endcase
    end else begin
      send_word(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int ph;
    int target;
    sb = new();
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_text  = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    words_sent         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: byte extremes, all simple escapes, unknown and NUL escapes.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\\q");
    send_word(BSLASH, 1'b0);
    send_word(8'h00, 1'b0);
    // zero value, 2- and 3-byte forms, uppercase ends a run, empty run
    send_text("\\u0000\\u00e9\\uffff\\u41G\\ux");
    // good pair, lone low half, high half then plain byte / \n / bad low
    send_text("\\ud83d\\ude00\\udc00\\ud800x\\udbff\\n\\ud800\\u0041");
    // end of text in every open position
    send_text("\\");
    send_word(8'h00, 1'b1);
    send_text("\\u12");
    send_word(8'hFF, 1'b1);
    send_text("\\ud800");
    send_word(8'h00, 1'b1);
    send_text("\\ud800\\");
    send_word(8'h00, 1'b1);
    send_text("\\ud800\\udc");
    send_word(8'h00, 1'b1);

    // Random phases with different idle/stall mixes.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_random_token();
    end
    @(negedge clk) in_ch.valid <= 1'b0;

    // Drain; the watchdog covers a block that stops producing.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_json_escape_to_utf8_decoder: clean");
    end else begin
      $display("tb_json_escape_to_utf8_decoder: errors");
    end
    $finish;
  end

endmodule
